// ===== rtl/rgbshp_pkg.sv =====
`timescale 1ns / 1ps

package rgbshp_pkg;

   // Frame geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int DIM_MIN    = 3;

   // Counter and dimension widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int IROW_W = ROW_W + 1;
   localparam int WD_W   = $clog2(MAX_WIDTH + 1);
   localparam int HT_W   = $clog2(MAX_HEIGHT + 1);

   // Register and sample widths
   localparam int GAIN_W    = 8;
   localparam int GAIN_FRAC = 4;
   localparam int DIM_REG_W = 11;
   localparam int CH_W      = 8;
   localparam int NUM_CH    = 3;
   localparam int PIX_W     = CH_W * NUM_CH;

   // Configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   localparam logic [GAIN_W-1:0]    GAIN_RESET   = 8'd64;
   localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 11'd580;
   localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 11'd372;

   typedef enum logic [1:0] {
      REG_GAIN   = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } reg_index_type;

   // Gain and clamped frame size as seen by the datapath
   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [WD_W-1:0]   width;
      logic [HT_W-1:0]   height;
   } cfg_type;

   // One window column handed from front to back
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] pixel;
      logic             emit;
      logic             border;
      logic             last;
   } column_type;

endpackage

// ===== rtl/rgbshp_csr.sv =====
`timescale 1ns / 1ps

module rgbshp_csr import rgbshp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [DIM_REG_W-1:0] width_ff, width_in;
   logic [DIM_REG_W-1:0] height_ff, height_in;
   reg_index_type        index;
   logic                 wr_en;

   assign index  = reg_index_type'(paddr[CSR_AW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      gain_in   = gain_ff;
      width_in  = width_ff;
      height_in = height_ff;
      prdata    = '0;
      case (index)
         REG_GAIN: begin
            prdata = CSR_DW'(gain_ff);
            if (wr_en) begin
               gain_in = pwdata[GAIN_W-1:0];
            end
         end
         REG_WIDTH: begin
            prdata = CSR_DW'(width_ff);
            if (wr_en) begin
               width_in = pwdata[DIM_REG_W-1:0];
            end
         end
         REG_HEIGHT: begin
            prdata = CSR_DW'(height_ff);
            if (wr_en) begin
               height_in = pwdata[DIM_REG_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         gain_ff   <= gain_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamp frame size to the supported range
   always_comb begin
      cfg.gain = gain_ff;
      if (int'(width_ff) < DIM_MIN) begin
         cfg.width = WD_W'(DIM_MIN);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         cfg.width = WD_W'(MAX_WIDTH);
      end else begin
         cfg.width = WD_W'(width_ff);
      end
      if (int'(height_ff) < DIM_MIN) begin
         cfg.height = HT_W'(DIM_MIN);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         cfg.height = HT_W'(MAX_HEIGHT);
      end else begin
         cfg.height = HT_W'(height_ff);
      end
   end

endmodule

// ===== rtl/rgbshp_front.sv =====
`timescale 1ns / 1ps

module rgbshp_front import rgbshp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            push,
   output logic            full,
   input  logic [CH_W-1:0] red_in,
   input  logic [CH_W-1:0] green_in,
   input  logic [CH_W-1:0] blue_in,
   input  logic            flush,
   input  logic            q_full,
   output logic            q_push,
   output column_type      q_item
);

   // Raster counters
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [IROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;

   // Stage holding the line memory read
   logic              f1_valid_ff, f1_valid_in;
   logic [PIX_W-1:0]  f1_pixel_ff;
   logic              f1_write_ff;
   logic [COL_W-1:0]  f1_addr_ff;
   logic              f1_emit_ff, f1_border_ff, f1_last_ff;

   // Both lines in one entry: older above, newer below
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;
   logic [2*PIX_W-1:0] wr_data;
   logic               wr_en;

   logic             accept, in_done, drop, take, f1_go;
   logic             emit, border, last;
   logic [PIX_W-1:0] pixel;
   int               w, h, col_next, ocol_next;

   assign w = int'(cfg.width);
   assign h = int'(cfg.height);

   assign f1_go  = f1_valid_ff && !q_full;
   assign full   = f1_valid_ff && q_full;
   assign accept = push && !full;

   assign in_done = int'(in_row_ff) >= h;
   assign drop    = !in_done && flush;
   assign take    = accept && !drop;
   assign pixel   = in_done ? '0 : {blue_in, green_in, red_in};

   // Output starts once one line plus one pixel has entered
   assign emit = !(((in_row_ff == '0) && (int'(in_col_ff) <= w)) ||
                   ((int'(in_row_ff) == 1) && (in_col_ff == '0)));

   assign border = (out_row_ff == '0) || (int'(out_row_ff) >= h - 1) ||
                   (out_col_ff == '0) || (int'(out_col_ff) >= w - 1);
   assign last   = (int'(out_row_ff) >= h - 1) && (int'(out_col_ff) >= w - 1);

   assign col_next  = int'(in_col_ff) + 1;
   assign ocol_next = int'(out_col_ff) + 1;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (take) begin
         if (col_next >= w) begin
            in_col_in = '0;
            in_row_in = IROW_W'(int'(in_row_ff) + 1);
         end else begin
            in_col_in = COL_W'(col_next);
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (ocol_next >= w) begin
               out_col_in = '0;
               out_row_in = ROW_W'(int'(out_row_ff) + 1);
            end else begin
               out_col_in = COL_W'(ocol_next);
            end
         end
      end
   end

   always_comb begin
      if (take) begin
         f1_valid_in = 1'b1;
      end else if (f1_go) begin
         f1_valid_in = 1'b0;
      end else begin
         f1_valid_in = f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         f1_pixel_ff  <= pixel;
         f1_write_ff  <= !in_done;
         f1_addr_ff   <= in_col_ff;
         f1_emit_ff   <= emit;
         f1_border_ff <= border;
         f1_last_ff   <= last;
      end
   end

   // Shift the column down one line as the item leaves the stage
   assign wr_en   = f1_go && f1_write_ff;
   assign wr_data = {rd_ff[PIX_W-1:0], f1_pixel_ff};

   always_ff @(posedge clock) begin
      if (take) begin
         if (wr_en && (f1_addr_ff == in_col_ff)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= line_mem[in_col_ff];
         end
      end
      if (wr_en) begin
         line_mem[f1_addr_ff] <= wr_data;
      end
   end

   assign q_push        = f1_go;
   assign q_item.top    = rd_ff[2*PIX_W-1:PIX_W];
   assign q_item.mid    = rd_ff[PIX_W-1:0];
   assign q_item.pixel  = f1_pixel_ff;
   assign q_item.emit   = f1_emit_ff;
   assign q_item.border = f1_border_ff;
   assign q_item.last   = f1_last_ff;

endmodule

// ===== rtl/rgbshp_queue.sv =====
`timescale 1ns / 1ps

module rgbshp_queue import rgbshp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  column_type push_item,
   output logic       full,
   input  logic       pop,
   output column_type pop_item,
   output logic       empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   column_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(int'(wr_ptr_ff) + 1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(int'(rd_ptr_ff) + 1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(int'(count_ff) + 1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(int'(count_ff) - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/rgbshp_back.sv =====
`timescale 1ns / 1ps

module rgbshp_back import rgbshp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  column_type      q_item,
   input  logic            q_empty,
   output logic            q_pop,
   input  logic            pop,
   output logic            empty,
   output logic [CH_W-1:0] red_out,
   output logic [CH_W-1:0] green_out,
   output logic [CH_W-1:0] blue_out,
   output logic            frame_last
);

   localparam int SUM_W  = CH_W + 3;
   localparam int DIFF_W = SUM_W + 1;
   localparam int PROD_W = DIFF_W + GAIN_W + 1;
   localparam int SHIFT  = GAIN_FRAC + 3;
   localparam int Q_W    = PROD_W - SHIFT;
   localparam int Y_W    = Q_W + 1;
   localparam int CH_MAX = (1 << CH_W) - 1;

   logic [PIX_W-1:0] window_ff [9];

   logic b1_valid_ff, b1_border_ff, b1_last_ff;

   logic                     b2_valid_ff, b2_border_ff, b2_last_ff;
   logic [PIX_W-1:0]         b2_center_ff;
   logic signed [DIFF_W-1:0] b2_diff_ff [NUM_CH];
   logic signed [DIFF_W-1:0] diff [NUM_CH];

   logic                     b3_valid_ff, b3_border_ff, b3_last_ff;
   logic [PIX_W-1:0]         b3_center_ff;
   logic signed [PROD_W-1:0] b3_prod_ff [NUM_CH];
   logic signed [PROD_W-1:0] prod [NUM_CH];

   logic             out_valid_ff, out_last_ff;
   logic [PIX_W-1:0] out_pixel_ff;
   logic [PIX_W-1:0] result;

   logic adv;

   // Advance the whole back end whenever the output register frees up
   assign adv   = !out_valid_ff || pop;
   assign q_pop = adv && !q_empty;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r*3]   <= window_ff[r*3+1];
            window_ff[r*3+1] <= window_ff[r*3+2];
         end
         window_ff[2] <= q_item.top;
         window_ff[5] <= q_item.mid;
         window_ff[8] <= q_item.pixel;
      end
   end

   // 8*center minus the neighbor sum, per channel
   always_comb begin
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] center8;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum = '0;
         for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
               sum = sum + SUM_W'(window_ff[i][ch*CH_W +: CH_W]);
            end
         end
         center8  = {window_ff[4][ch*CH_W +: CH_W], 3'b000};
         diff[ch] = $signed({1'b0, center8}) - $signed({1'b0, sum});
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         prod[ch] = PROD_W'($signed({1'b0, cfg.gain})) * PROD_W'(b2_diff_ff[ch]);
      end
   end

   // Floor by arithmetic shift, add center, clamp to sample range; border pixels pass the center through
   always_comb begin
      logic signed [Q_W-1:0] q;
      logic signed [Y_W-1:0] y;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         q = Q_W'(b3_prod_ff[ch] >>> SHIFT);
         y = Y_W'(q) + $signed({{(Y_W-CH_W){1'b0}}, b3_center_ff[ch*CH_W +: CH_W]});
         if (b3_border_ff) begin
            result[ch*CH_W +: CH_W] = b3_center_ff[ch*CH_W +: CH_W];
         end else if (y < 0) begin
            result[ch*CH_W +: CH_W] = '0;
         end else if (y > Y_W'(CH_MAX)) begin
            result[ch*CH_W +: CH_W] = CH_W'(CH_MAX);
         end else begin
            result[ch*CH_W +: CH_W] = y[CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= q_pop && q_item.emit;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         out_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_border_ff <= q_item.border;
         b1_last_ff   <= q_item.last;

         b2_border_ff <= b1_border_ff;
         b2_last_ff   <= b1_last_ff;
         b2_center_ff <= window_ff[4];
         b2_diff_ff   <= diff;

         b3_border_ff <= b2_border_ff;
         b3_last_ff   <= b2_last_ff;
         b3_center_ff <= b2_center_ff;
         b3_prod_ff   <= prod;

         out_last_ff  <= b3_last_ff;
         out_pixel_ff <= result;
      end
   end

   assign empty      = !out_valid_ff;
   assign red_out    = out_pixel_ff[0*CH_W +: CH_W];
   assign green_out  = out_pixel_ff[1*CH_W +: CH_W];
   assign blue_out   = out_pixel_ff[2*CH_W +: CH_W];
   assign frame_last = out_last_ff;

endmodule

// ===== rtl/rgb_sharpen_3x3_filter_top.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                   Beat moves when
// -------   -------------------------------------   ---------------------------
// req       req_push/full, rgb samples, flush        push high, full low
// rsp       rsp_empty/pop, rgb samples, frame_last   pop high, empty low
// csr       APB: psel/penable/pwrite/paddr/...       psel, penable, pwrite high
//
// One beat per clock in and out while rsp pops, sustained. The req beat's edge
// starts the line memory read; the pixel then passes the column queue, window,
// difference, product, then the clamping output register. Results trail
// their pixels by one line plus one pixel; width+1 flush beats drain the tail.
// Reset clears counters and handshake state, not the line memory or window.
// A stalled rsp side freezes the back end; the queue fills and req_full rises.

module rgb_sharpen_3x3_filter_top import rgbshp_pkg::*; (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_push,
   output logic              req_full,
   input  logic [CH_W-1:0]   req_red_in,
   input  logic [CH_W-1:0]   req_green_in,
   input  logic [CH_W-1:0]   req_blue_in,
   input  logic              req_flush,

   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [CH_W-1:0]   rsp_red_out,
   output logic [CH_W-1:0]   rsp_green_out,
   output logic [CH_W-1:0]   rsp_blue_out,
   output logic              rsp_frame_last,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type    cfg;
   column_type push_item;
   column_type pop_item;
   logic       q_push, q_full, q_pop, q_empty;

   // Hold gain and frame size; clamp size to the supported range
   rgbshp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Track raster position, drop early flushes, read and update line memory,
   // tag each column with emit/border/last
   rgbshp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (req_push),
      .full     (req_full),
      .red_in   (req_red_in),
      .green_in (req_green_in),
      .blue_in  (req_blue_in),
      .flush    (req_flush),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   // Decouple the front from output back-pressure
   rgbshp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   // Shift the window, sharpen or pass through, and hold the result
   rgbshp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_item     (pop_item),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .pop        (rsp_pop),
      .empty      (rsp_empty),
      .red_out    (rsp_red_out),
      .green_out  (rsp_green_out),
      .blue_out   (rsp_blue_out),
      .frame_last (rsp_frame_last)
   );

endmodule
